// ===== hdl/hilbert_cell_id_codec_top_macros.svh =====
// ----------------------------------------------------------------------------
// hilbert cell id codec assertion macros
// concurrent assertion wrappers used by the hcc_back module
// ----------------------------------------------------------------------------
`ifndef HILBERT_CELL_ID_CODEC_TOP_MACROS_SVH
`define HILBERT_CELL_ID_CODEC_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define HCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge
`define HCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCC_ASSERT(lbl, prop, msg)
`define HCC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/hcc_pkg.sv =====
// ----------------------------------------------------------------------------
// hcc_pkg
// shared types, codes and helpers of the hilbert cell id codec
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcc_pkg;

    localparam int COORD_W = 30;
    localparam int ID_W    = 64;
    localparam int RID_W   = 62;
    localparam int LVL_W   = 5;
    localparam int CMD_W   = 3;
    localparam int ST_W    = 3;
    localparam int D_W     = 60;

    localparam int MAX_LEVEL_DEF = 30;

    localparam logic [CMD_W-1:0] CMD_ENCODE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DECODE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PARENT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHILDREN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_LVL_RANGE = 3'd1;
    localparam logic [ST_W-1:0] ST_OUTSIDE   = 3'd2;
    localparam logic [ST_W-1:0] ST_ID_ZERO   = 3'd3;
    localparam logic [ST_W-1:0] ST_TOO_DEEP  = 3'd4;
    localparam logic [ST_W-1:0] ST_NO_CHILD  = 3'd5;

    // one classified command waiting for the back end
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ST_W-1:0]    status;
        logic               calc;
        logic [LVL_W-1:0]   calc_lvl;
        logic [LVL_W-1:0]   level_out;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RID_W-1:0]   d;
        logic [ID_W-1:0]    id;
        logic [RID_W-1:0]   rid;
    } hcc_entry_t;

    // marker bit at 2*lvl+1, index below it, low bit set
    function automatic logic [RID_W-1:0] pack_id(input logic [LVL_W-1:0] lvl,
                                                 input logic [RID_W-1:0] d);
        logic [RID_W-1:0] marker;
        marker = {{(RID_W-1){1'b0}}, 1'b1} << {lvl, 1'b1};
        return marker | {d[RID_W-2:0], 1'b1};
    endfunction

endpackage

// ===== hdl/hcc_front.sv =====
// ----------------------------------------------------------------------------
// hcc_front
// holds max_level, finds the id level and classifies each command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcc_front
    import hcc_pkg::*;
#(
    parameter int MAX_LEVEL_BOUND = MAX_LEVEL_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LVL_W-1:0]   cfg_wdata,
    input  logic [CMD_W-1:0]   command,
    input  logic [COORD_W-1:0] x_coord,
    input  logic [COORD_W-1:0] y_coord,
    input  logic [LVL_W-1:0]   grid_level,
    input  logic [ID_W-1:0]    cell_id,
    output logic               known,
    output hcc_entry_t         entry
);

    logic [LVL_W-1:0] max_level_reg;
    logic [5:0]       msb;
    logic [5:0]       msb_m1;
    logic [LVL_W-1:0] lvl;
    logic [RID_W-1:0] idx;
    logic             id_zero;
    logic             enc_out;
    logic             pt_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg <= LVL_W'(MAX_LEVEL_BOUND);
        end
        else if (cfg_we && cfg_wdata != '0 && cfg_wdata <= LVL_W'(MAX_LEVEL_BOUND))
        begin
            max_level_reg <= cfg_wdata;
        end
    end

    // leading one of the id
    always_comb
    begin
        msb = '0;
        for (int i = 1; i < ID_W; i++)
        begin
            if (cell_id[i])
            begin
                msb = 6'(i);
            end
        end
    end

    assign msb_m1  = msb - 6'd1;
    assign lvl     = (msb == '0) ? '0 : msb_m1[5:1];
    assign idx     = cell_id[RID_W:1] & ~({RID_W{1'b1}} << {lvl, 1'b0});
    assign id_zero = (cell_id == '0);
    assign enc_out = ((x_coord >> grid_level) != '0) || ((y_coord >> grid_level) != '0);
    assign pt_out  = ((x_coord >> lvl) != '0) || ((y_coord >> lvl) != '0);
    assign known   = (command <= CMD_CONTAINS);

    always_comb
    begin
        entry           = '0;
        entry.cmd       = command;
        entry.x         = x_coord;
        entry.y         = y_coord;
        entry.id        = cell_id;
        entry.d         = idx;
        case (command)
            CMD_ENCODE:
            begin
                if (grid_level > max_level_reg)
                begin
                    entry.status = ST_LVL_RANGE;
                end
                else if (enc_out)
                begin
                    entry.status = ST_OUTSIDE;
                end
                else
                begin
                    entry.calc      = 1'b1;
                    entry.calc_lvl  = grid_level;
                    entry.level_out = grid_level;
                end
            end
            CMD_DECODE, CMD_CONTAINS:
            begin
                if (id_zero)
                begin
                    entry.status = ST_ID_ZERO;
                end
                else if (lvl > max_level_reg)
                begin
                    entry.status    = ST_TOO_DEEP;
                    entry.level_out = lvl;
                end
                else if (command == CMD_CONTAINS && pt_out)
                begin
                    entry.status    = ST_OUTSIDE;
                    entry.level_out = lvl;
                end
                else
                begin
                    entry.calc      = 1'b1;
                    entry.calc_lvl  = lvl;
                    entry.level_out = lvl;
                end
            end
            CMD_PARENT:
            begin
                if (id_zero)
                begin
                    entry.status = ST_ID_ZERO;
                end
                else if (lvl == '0)
                begin
                    entry.rid = cell_id[RID_W-1:0];
                end
                else
                begin
                    entry.rid       = pack_id(lvl - LVL_W'(1), idx >> 2);
                    entry.level_out = lvl;
                end
            end
            CMD_CHILDREN:
            begin
                if (id_zero)
                begin
                    entry.status = ST_ID_ZERO;
                end
                else if (lvl >= max_level_reg)
                begin
                    entry.status    = ST_NO_CHILD;
                    entry.level_out = lvl;
                end
                else
                begin
                    entry.rid       = pack_id(lvl + LVL_W'(1), idx << 2);
                    entry.level_out = lvl;
                end
            end
            default:
            begin
                entry.status = ST_OK;
            end
        endcase
    end

endmodule

// ===== hdl/hcc_queue.sv =====
// ----------------------------------------------------------------------------
// hcc_queue
// two-entry queue of classified commands between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcc_queue
    import hcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  hcc_entry_t wr_entry,
    input  logic       pop,
    output hcc_entry_t rd_entry,
    output logic       full,
    output logic       empty
);

    hcc_entry_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/hcc_back.sv =====
// ----------------------------------------------------------------------------
// hcc_back
// sequencer that walks the hilbert levels one per cycle and issues results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hilbert_cell_id_codec_top_macros.svh"

module hcc_back
    import hcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  hcc_entry_t         q_entry,
    output logic               q_pop,
    output logic [RID_W-1:0]   result_id,
    output logic [COORD_W-1:0] x_out,
    output logic [COORD_W-1:0] y_out,
    output logic [LVL_W-1:0]   level_out,
    output logic               inside_res,
    output logic [ST_W-1:0]    status,
    output logic               last,
    output logic               out_valid,
    input  logic               out_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         kid_reg;
    logic               last_reg;
    hcc_entry_t         e_reg;
    logic [LVL_W-1:0]   step_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [COORD_W-1:0] x_next;
    logic [COORD_W-1:0] y_next;
    logic [RID_W-1:0]   t_reg;
    logic [D_W-1:0]     acc_reg;
    logic [RID_W-1:0]   rid_reg;
    logic [COORD_W-1:0] xo_reg;
    logic [COORD_W-1:0] yo_reg;
    logic [LVL_W-1:0]   lvo_reg;
    logic               ins_reg;
    logic [ST_W-1:0]    st_reg;
    logic               is_dec;
    logic [LVL_W-1:0]   bit_idx;
    logic               rx;
    logic               ry;
    logic [COORD_W-1:0] low_mask;
    logic [RID_W-1:0]   enc_id;

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign is_dec   = (e_reg.cmd == CMD_DECODE);
    assign bit_idx  = e_reg.calc_lvl - LVL_W'(1) - step_reg;
    assign low_mask = ~({COORD_W{1'b1}} << step_reg);
    assign enc_id   = pack_id(e_reg.calc_lvl, {2'b00, acc_reg});

    // one hilbert level per cycle in either direction
    always_comb
    begin
        if (is_dec)
        begin
            rx = t_reg[1];
            ry = t_reg[0] ^ t_reg[1];
        end
        else
        begin
            rx = x_reg[bit_idx];
            ry = y_reg[bit_idx];
        end
        x_next = x_reg;
        y_next = y_reg;
        if (!ry)
        begin
            if (rx)
            begin
                x_next = is_dec ? (~y_reg & low_mask) : ~y_reg;
                y_next = is_dec ? (~x_reg & low_mask) : ~x_reg;
            end
            else
            begin
                x_next = y_reg;
                y_next = x_reg;
            end
        end
        if (is_dec)
        begin
            x_next = x_next | (COORD_W'(rx) << step_reg);
            y_next = y_next | (COORD_W'(ry) << step_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            e_reg    <= q_entry;
            step_reg <= '0;
            acc_reg  <= '0;
            t_reg    <= q_entry.d;
            x_reg    <= (q_entry.cmd == CMD_DECODE) ? '0 : q_entry.x;
            y_reg    <= (q_entry.cmd == CMD_DECODE) ? '0 : q_entry.y;
        end
        else if (state_reg == S_RUN)
        begin
            if (!e_reg.calc)
            begin
                rid_reg <= e_reg.rid;
                xo_reg  <= '0;
                yo_reg  <= '0;
                ins_reg <= 1'b0;
            end
            else if (step_reg == e_reg.calc_lvl)
            begin
                rid_reg <= (e_reg.cmd == CMD_ENCODE) ? enc_id : '0;
                xo_reg  <= is_dec ? x_reg : '0;
                yo_reg  <= is_dec ? y_reg : '0;
                ins_reg <= (e_reg.cmd == CMD_CONTAINS) && ({2'b00, enc_id} == e_reg.id);
            end
            else
            begin
                step_reg <= step_reg + LVL_W'(1);
                acc_reg  <= {acc_reg[D_W-3:0], rx, rx ^ ry};
                t_reg    <= t_reg >> 2;
                x_reg    <= x_next;
                y_reg    <= y_next;
            end
        end
        else if (state_reg == S_OUT && out_ready && !last_reg)
        begin
            rid_reg <= rid_reg + RID_W'(2);
        end
        if (q_pop)
        begin
            lvo_reg <= q_entry.level_out;
            st_reg  <= q_entry.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kid_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        state_reg <= S_RUN;
                        kid_reg   <= '0;
                        last_reg  <= !(q_entry.cmd == CMD_CHILDREN && q_entry.status == ST_OK);
                    end
                end
                S_RUN:
                begin
                    if (!e_reg.calc || step_reg == e_reg.calc_lvl)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        if (last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            kid_reg  <= kid_reg + 2'd1;
                            last_reg <= (kid_reg == 2'd2);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // entries without a level walk pass the id from the front straight through
    assign out_valid  = (state_reg == S_OUT);
    assign result_id  = rid_reg;
    assign x_out      = xo_reg;
    assign y_out      = yo_reg;
    assign level_out  = lvo_reg;
    assign inside_res = ins_reg;
    assign status     = st_reg;
    assign last       = last_reg;

    `HCC_ASSERT(a_err_last, (out_valid && status != ST_OK) |-> last, "error result not last")
    `HCC_ASSERT(a_err_zero, (out_valid && status != ST_OK) |-> (result_id == '0 && x_out == '0 && y_out == '0), "error result carries data")
    `HCC_ASSERT(a_run_next, (state_reg == S_RUN) |=> (state_reg == S_RUN || state_reg == S_OUT), "sequencer left run early")
    `HCC_ASSERT(a_pop_idle, q_pop |=> (state_reg == S_RUN), "pop without start")

endmodule

// ===== hdl/hilbert_cell_id_codec_top.sv =====
// ----------------------------------------------------------------------------
// hilbert_cell_id_codec_top
// hilbert curve cell id codec: encode, decode, parent, children, contains
// ----------------------------------------------------------------------------
// Items are classified on entry (id level, range checks, parent and child base
// ids) and parked in a two-entry queue, so the input keeps taking items while
// results wait, until the queue is full. The back sequencer walks the hilbert
// curve one level per cycle for encode, decode and contains; parent and error
// results skip the walk, and a valid children item gives four results. The back
// sequencer is the throughput limit. max_level resets to MAX_LEVEL_BOUND; writes
// outside 1..MAX_LEVEL_BOUND are dropped, and unknown commands are accepted and
// give no result.
`timescale 1ns / 1ps

module hilbert_cell_id_codec_top
    import hcc_pkg::*;
#(
    parameter int MAX_LEVEL_BOUND = MAX_LEVEL_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write
    input  logic               cfg_we,
    input  logic [LVL_W-1:0]   cfg_wdata,
    // input items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   command,
    input  logic [COORD_W-1:0] x_coord,
    input  logic [COORD_W-1:0] y_coord,
    input  logic [LVL_W-1:0]   grid_level,
    input  logic [ID_W-1:0]    cell_id,
    // result items
    output logic               out_valid,
    input  logic               out_ready,
    output logic [RID_W-1:0]   result_id,
    output logic [COORD_W-1:0] x_out,
    output logic [COORD_W-1:0] y_out,
    output logic [LVL_W-1:0]   level_out,
    output logic               inside_res,
    output logic [ST_W-1:0]    status,
    output logic               last
);

    hcc_entry_t f_entry;
    hcc_entry_t q_entry;
    logic       known;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic       push;

    // unknown commands are taken but never queued
    assign in_ready = !q_full;
    assign push     = in_valid && in_ready && known;

    hcc_front #(
        .MAX_LEVEL_BOUND (MAX_LEVEL_BOUND)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .command    (command),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .grid_level (grid_level),
        .cell_id    (cell_id),
        .known      (known),
        .entry      (f_entry)
    );

    hcc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (f_entry),
        .pop      (q_pop),
        .rd_entry (q_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    // level walk and result issue
    hcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_entry    (q_entry),
        .q_pop      (q_pop),
        .result_id  (result_id),
        .x_out      (x_out),
        .y_out      (y_out),
        .level_out  (level_out),
        .inside_res (inside_res),
        .status     (status),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule
